// ===== sv/cs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the comment stripper: character codes, scan modes, result and queue word types.
// No dependencies.
package cs_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam int CS_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4
    } t_mode;

    typedef struct packed {
        logic       text_done;
        logic       run_last;
        logic       byte_valid;
        logic [7:0] out_byte;
    } t_res;

    // One queue word: the results caused by one input word.
    typedef struct packed {
        logic two;
        t_res res1;
        t_res res0;
    } t_pkt;

    // Outcome of one byte handled as normal code.
    typedef struct packed {
        logic in_string;
        logic to_slash;
        logic keep;
    } t_nb;

    function automatic t_nb nb_step(logic in_string, logic [7:0] last_kept, logic [7:0] b);
        t_nb r;
        logic toggle;
        toggle      = (b == CH_QUOTE) && (last_kept != CH_BSLASH);
        r.in_string = in_string;
        r.to_slash  = 1'b0;
        r.keep      = 1'b1;
        if (in_string) begin
            if (toggle) r.in_string = 1'b0;
        end else if (b == CH_SLASH) begin
            r.to_slash = 1'b1;
            r.keep     = 1'b0;
        end else if (toggle) begin
            r.in_string = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== sv/cs_front.sv =====
`timescale 1ns / 1ps
// Front end of the comment stripper: scan state, classifies each input word into 0..2 results.
// Depends on cs_pkg.
module cs_front
    import cs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_push,
    output t_pkt       o_pkt
);

    t_mode      r_mode, n_mode;
    logic       r_in_string, n_in_string;
    logic [7:0] r_last_kept, n_last_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_in_string <= 1'b0;
            r_last_kept <= 8'd0;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_in_string <= n_in_string;
            r_last_kept <= n_last_kept;
        end
    end

    always_comb begin
        t_mode      mode;
        logic       instr;
        logic [7:0] lk;
        logic [7:0] kb0;
        logic [7:0] kb1;
        logic [1:0] cnt;
        t_nb        nb;
        logic       pre;

        mode  = r_mode;
        instr = r_in_string;
        lk    = r_last_kept;
        kb0   = 8'd0;
        kb1   = 8'd0;
        cnt   = 2'd0;
        pre   = 1'b0;
        nb    = nb_step(instr, lk, i_byte);

        unique case (r_mode)
            MODE_SLASH: begin
                if (i_byte == CH_SLASH) begin
                    mode = MODE_LINE;
                end else if (i_byte == CH_STAR) begin
                    mode = MODE_BLOCK;
                end else begin
                    // release the held slash ahead of this byte
                    pre  = 1'b1;
                    kb0  = CH_SLASH;
                    cnt  = 2'd1;
                    nb   = nb_step(instr, CH_SLASH, i_byte);
                    lk   = CH_SLASH;
                    mode = nb.to_slash ? MODE_SLASH : MODE_NORMAL;
                    instr = nb.in_string;
                    if (nb.keep) begin
                        kb1 = i_byte;
                        cnt = 2'd2;
                        lk  = i_byte;
                    end
                end
            end
            MODE_LINE: begin
                if (i_byte == CH_NL) begin
                    mode  = nb.to_slash ? MODE_SLASH : MODE_NORMAL;
                    instr = nb.in_string;
                    if (nb.keep) begin
                        kb0 = i_byte;
                        cnt = 2'd1;
                        lk  = i_byte;
                    end
                end
            end
            MODE_BLOCK: begin
                if (i_byte == CH_STAR) mode = MODE_BSTAR;
            end
            MODE_BSTAR: begin
                if (i_byte == CH_SLASH) mode = MODE_NORMAL;
                else if (i_byte != CH_STAR) mode = MODE_BLOCK;
            end
            default: begin
                mode  = nb.to_slash ? MODE_SLASH : MODE_NORMAL;
                instr = nb.in_string;
                if (nb.keep) begin
                    kb0 = i_byte;
                    cnt = 2'd1;
                    lk  = i_byte;
                end
            end
        endcase

        // flush a slash still held at end of text
        if (i_end && mode == MODE_SLASH) begin
            if (cnt == 2'd0) kb0 = CH_SLASH;
            else kb1 = CH_SLASH;
            cnt = cnt + 2'd1;
            lk  = CH_SLASH;
        end

        if (i_end) begin
            n_mode      = MODE_NORMAL;
            n_in_string = 1'b0;
            n_last_kept = 8'd0;
        end else begin
            n_mode      = mode;
            n_in_string = instr;
            n_last_kept = lk;
        end

        o_pkt.two             = (cnt == 2'd2);
        o_pkt.res0.out_byte   = kb0;
        o_pkt.res0.byte_valid = (cnt != 2'd0);
        o_pkt.res0.run_last   = (cnt != 2'd2);
        o_pkt.res0.text_done  = i_end && (cnt != 2'd2);
        o_pkt.res1.out_byte   = kb1;
        o_pkt.res1.byte_valid = 1'b1 | pre;
        o_pkt.res1.run_last   = 1'b1;
        o_pkt.res1.text_done  = i_end;
        o_push                = i_accept && ((cnt != 2'd0) || i_end);
    end

endmodule

// ===== sv/cs_queue.sv =====
`timescale 1ns / 1ps
// Short queue of result words between the front and back of the comment stripper.
// Depends on cs_pkg.
module cs_queue
    import cs_pkg::*;
#(
    parameter int DEPTH = CS_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output t_pkt o_pkt,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_pkt   = r_mem[r_rd];

    function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= wrap_inc(r_wr);
            if (do_pop) r_rd <= wrap_inc(r_rd);
            if (do_push && !do_pop) r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ===== sv/cs_back.sv =====
`timescale 1ns / 1ps
// Back end of the comment stripper: unpacks queue words into single results on an output register.
// Depends on cs_pkg.
module cs_back
    import cs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pkt       i_pkt,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res
);

    logic r_valid;
    logic r_sel;
    t_res r_res;
    logic load;
    logic last_of_pkt;

    assign load        = (!r_valid || i_ready) && !i_empty;
    assign last_of_pkt = r_sel || !i_pkt.two;
    assign o_pop       = load && last_of_pkt;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !last_of_pkt;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_res <= r_sel ? i_pkt.res1 : i_pkt.res0;
    end

endmodule

// ===== sv/comment_stripper.sv =====
`timescale 1ns / 1ps
// Top level of the comment stripper: front end, result queue and back end.
// Depends on cs_pkg, cs_front, cs_queue, cs_back.
//
// Usage:
//   Feed source text on the slave stream, one byte per word, with tlast on the final
//   byte of the text. Line comments and block comments outside double-quoted strings
//   are dropped; every kept byte comes out on the master stream, one word each.
//   tuser on the output carries byte_valid (bit 0) and text_done (bit 1); tlast marks
//   the last result caused by one input word. A text whose final byte keeps nothing
//   ends with a bare end marker (byte_valid 0, data 0, tlast 1, text_done 1).
//   A result passes through the queue and then the output register.
//   Throughput: one input word per cycle while the queue has room; one output word
//   per cycle while the receiver is ready. An input word that releases a held slash
//   yields two results, which the queue absorbs.
//   When the receiver stalls, the output register holds its word, the queue fills
//   and s_axis_tready falls once it is full; nothing is lost.
//   Reset (synchronous, active low) returns the scan state to normal code outside a
//   string and empties the queue and the output register.
module comment_stripper
    import cs_pkg::*;
#(
    parameter int QUEUE_DEPTH = CS_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // text_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] text_done
    output logic       m_axis_tlast    // run_last
);

    logic accept;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    t_pkt f_pkt;
    t_pkt q_pkt;
    t_res res;

    // take a word whenever the queue has room
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_push   (push),
        .o_pkt    (f_pkt)
    );

    cs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (f_pkt),
        .i_pop   (pop),
        .o_pkt   (q_pkt),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (q_pkt),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = res.out_byte;
    assign m_axis_tuser = {res.text_done, res.byte_valid};
    assign m_axis_tlast = res.run_last;

endmodule
